// File: src/annexb_pkg.sv
// Shared types, constants and helpers for the Annex B unit splitter.
// No dependencies; imported by annexb_nal_unit_splitter.
package annexb_pkg;

    localparam int MAX_PACKET_BYTES = 65536;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int EXT_W            = (POS_W > 16) ? POS_W : 16;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PACKET_BYTES);

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0]  START_BYTE = 8'h01;
    localparam logic [13:0] INDEX_MAX  = 14'h3FFF;

    typedef struct packed {
        logic [15:0] unit_offset;
        logic [15:0] unit_length;
        logic [4:0]  nal_type;
        logic [13:0] unit_index;
        logic        last_unit;
        logic        too_long;
    } t_record;

    function automatic logic [15:0] sat16(input logic [POS_W-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        return (e > EXT_W'(16'hFFFF)) ? 16'hFFFF : e[15:0];
    endfunction

    function automatic logic [13:0] inc_sat(input logic [13:0] v);
        return (v < INDEX_MAX) ? v + 14'd1 : v;
    endfunction

endpackage

// File: src/annexb_nal_unit_splitter.sv
// Annex B start-code scanner: one byte per transaction in, one unit record per transaction out.
// Depends on annexb_pkg.
// A record is written into the record queue when the byte that closes its unit is accepted.
// Throughput: one byte per cycle while o_stall is low; a four-entry record queue holds up to two records per byte.
// Input stalls only while fewer than two queue entries are free.
// Reset (i_rst_n low, synchronous) clears scan state and empties the queue.
module annexb_nal_unit_splitter
    import annexb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_unit_offset,
    output logic [15:0] o_unit_length,
    output logic [4:0]  o_nal_type,
    output logic [13:0] o_unit_index,
    output logic        o_last_unit,
    output logic        o_too_long
);

    logic [23:0]      r_hist;
    logic [POS_W-1:0] r_pos;
    logic             r_pend_valid;
    logic [POS_W-1:0] r_pend_off;
    logic [4:0]       r_pend_type;
    logic             r_type_cap;
    logic [13:0]      r_units;
    logic             r_ovf;

    logic [23:0]      n_hist;
    logic [POS_W-1:0] n_pos;
    logic             n_pend_valid;
    logic [POS_W-1:0] n_pend_off;
    logic [4:0]       n_pend_type;
    logic             n_type_cap;
    logic [13:0]      n_units;
    logic             n_ovf;

    t_record          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic             accept;
    logic             pop;
    logic             sat;
    logic             code_hit;
    logic             short_pkt;
    logic [POS_W-1:0] start;
    logic [4:0]       cap_type;
    logic             cap_done;
    logic             rec0_v;
    logic             rec1_v;
    t_record          rec0;
    t_record          rec1;
    logic [1:0]       wr_cnt;

    assign accept  = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;
    assign o_stall = r_count > CNT_W'(FIFO_DEPTH - 2);
    assign o_valid = r_count != '0;

    always_comb begin
        sat       = r_pos == MAX_POS;
        start     = r_pos - POS_W'(3);
        code_hit  = !sat && (r_pos >= POS_W'(3)) && (r_hist == 24'd0)
                    && (i_data_byte == START_BYTE);
        cap_type  = r_pend_type;
        cap_done  = r_type_cap;
        if (!sat && r_pend_valid && !r_type_cap) begin
            cap_type = i_data_byte[4:0];
            cap_done = 1'b1;
        end

        n_pos        = sat ? r_pos : r_pos + POS_W'(1);
        n_hist       = sat ? r_hist : {r_hist[15:0], i_data_byte};
        n_ovf        = r_ovf || sat;
        n_pend_valid = r_pend_valid || code_hit;
        n_pend_off   = code_hit ? start : r_pend_off;
        n_pend_type  = code_hit ? 5'd0 : cap_type;
        n_type_cap   = code_hit ? 1'b0 : cap_done;

        rec0.unit_offset = sat16(r_pend_off);
        rec0.unit_length = sat16(start - r_pend_off - POS_W'(4));
        rec0.nal_type    = cap_type;
        rec0.unit_index  = r_units;
        rec0.last_unit   = 1'b0;
        rec0.too_long    = r_ovf;

        short_pkt = i_last_byte && (n_pos < POS_W'(5));
        rec0_v    = code_hit && r_pend_valid && !short_pkt;
        n_units   = rec0_v ? inc_sat(r_units) : r_units;

        rec1.unit_offset = sat16(n_pend_off);
        rec1.unit_length = sat16(n_pos - n_pend_off - POS_W'(4));
        rec1.nal_type    = n_pend_type;
        rec1.unit_index  = n_units;
        rec1.last_unit   = 1'b1;
        rec1.too_long    = n_ovf;
        rec1_v           = i_last_byte && !short_pkt && n_pend_valid;

        wr_cnt = {1'b0, rec0_v} + {1'b0, rec1_v};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist       <= '0;
            r_pos        <= '0;
            r_pend_valid <= 1'b0;
            r_type_cap   <= 1'b0;
            r_units      <= '0;
            r_ovf        <= 1'b0;
        end else if (accept) begin
            if (i_last_byte) begin
                r_hist       <= '0;
                r_pos        <= '0;
                r_pend_valid <= 1'b0;
                r_type_cap   <= 1'b0;
                r_units      <= '0;
                r_ovf        <= 1'b0;
            end else begin
                r_hist       <= n_hist;
                r_pos        <= n_pos;
                r_pend_valid <= n_pend_valid;
                r_type_cap   <= n_type_cap;
                r_units      <= n_units;
                r_ovf        <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_off  <= n_pend_off;
            r_pend_type <= n_pend_type;
        end
    end

    // record queue
    always_ff @(posedge i_clk) begin
        if (accept && (wr_cnt != 2'd0)) begin
            r_mem[r_wr] <= rec0_v ? rec0 : rec1;
        end
        if (accept && (wr_cnt == 2'd2)) begin
            r_mem[r_wr + PTR_W'(1)] <= rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (accept) begin
                r_wr <= r_wr + PTR_W'(wr_cnt);
            end
            if (pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            r_count <= r_count + (accept ? CNT_W'(wr_cnt) : CNT_W'(0))
                       - (pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    assign o_unit_offset = r_mem[r_rd].unit_offset;
    assign o_unit_length = r_mem[r_rd].unit_length;
    assign o_nal_type    = r_mem[r_rd].nal_type;
    assign o_unit_index  = r_mem[r_rd].unit_index;
    assign o_last_unit   = r_mem[r_rd].last_unit;
    assign o_too_long    = r_mem[r_rd].too_long;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("record queue count beyond depth");

    a_room_on_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> r_count <= CNT_W'(FIFO_DEPTH - 2))
        else $error("byte taken without room for two records");

    a_pos_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= MAX_POS)
        else $error("byte position beyond capacity");

    a_clear_after_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_byte) |=> (r_pos == '0) && !r_pend_valid && (r_units == '0))
        else $error("scan state not cleared after packet end");

    a_pop_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !accept) |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("queue count mismatch on pop");

endmodule
